// ===== src/big_reference_counter_table_top_defines.svh =====
// assertion macros shared by the reference counter table rtl
`ifndef BIG_REFERENCE_COUNTER_TABLE_TOP_DEFINES_SVH
`define BIG_REFERENCE_COUNTER_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked property with reset disable
`define BIGRC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// checked property that also holds through reset
`define BIGRC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BIGRC_ASSERT(label, clk, rst_n, prop, msg)
`define BIGRC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== src/bigrc_pkg.sv =====
// shared types and constants of the reference counter table
package bigrc_pkg;

	localparam int IDX_W = 15;
	localparam int CNT_W = 32;
	localparam int LIM_W = 15;

	localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 15'h7FFF;

	localparam logic KIND_TAKE = 1'b0;
	localparam logic KIND_DROP = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_INVALID  = 2'd3;

	typedef struct packed {
		logic             new_is_big;
		logic [IDX_W-1:0] new_index;
		logic [CNT_W-1:0] counter_value;
		logic [1:0]       status;
	} result_t;

	typedef struct packed {
		logic             mem_we;
		logic [IDX_W-1:0] mem_idx;
		logic [CNT_W-1:0] mem_wdata;
		logic             head_we;
		logic [IDX_W-1:0] head_next;
		result_t          res;
	} update_t;

endpackage

// ===== src/bigrc_mem.sv =====
// counter store: single write port, one registered read port
module bigrc_mem
	import bigrc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [CNT_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [CNT_W-1:0] rdata
);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bigrc_calc.sv =====
// read-modify-write decision for one take or drop word
module bigrc_calc
	import bigrc_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic             kind,
	input  logic             is_big,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [LIM_W-1:0] limit,
	input  logic [IDX_W-1:0] free_head,
	input  logic [CNT_W-1:0] rdata,
	output update_t          upd
);

	localparam logic [IDX_W:0] CAP_EXT = (IDX_W+1)'(CAPACITY);

	logic [CNT_W-1:0] lim_ext;
	logic [CNT_W-1:0] lim_p1;
	logic [CNT_W-1:0] inc_v;
	logic [CNT_W-1:0] dec_v;
	logic             head_full;
	logic             idx_bad;

	assign lim_ext   = {{(CNT_W-LIM_W){1'b0}}, limit};
	assign lim_p1    = lim_ext + CNT_W'(1);
	assign inc_v     = rdata + CNT_W'(1);
	assign dec_v     = rdata - CNT_W'(1);
	assign head_full = {1'b0, free_head} >= CAP_EXT;
	assign idx_bad   = {1'b0, entry_index} >= CAP_EXT;

	always_comb begin
		upd           = '0;
		upd.mem_idx   = entry_index;
		upd.head_next = free_head;
		if (kind == KIND_TAKE) begin
			if (!is_big) begin
				if (head_full) begin
					upd.res = '{1'b0, limit, '0, STAT_FULL};
				end else begin
					// pop the free head, its link becomes the new head
					upd.mem_we    = 1'b1;
					upd.mem_idx   = free_head;
					upd.mem_wdata = lim_p1;
					upd.head_we   = 1'b1;
					upd.head_next = rdata[IDX_W-1:0];
					upd.res       = '{1'b1, free_head, lim_p1, STAT_OK};
				end
			end else if (idx_bad) begin
				upd.res = '{1'b1, entry_index, '0, STAT_INVALID};
			end else if (rdata == COUNT_MAX) begin
				upd.res = '{1'b1, entry_index, rdata, STAT_OVERFLOW};
			end else begin
				upd.mem_we    = 1'b1;
				upd.mem_wdata = inc_v;
				upd.res       = '{1'b1, entry_index, inc_v, STAT_OK};
			end
		end else begin
			if (!is_big) begin
				upd.res = '{1'b0, entry_index, '0, STAT_INVALID};
			end else if (idx_bad) begin
				upd.res = '{1'b1, entry_index, '0, STAT_INVALID};
			end else if (rdata <= lim_ext) begin
				upd.res = '{1'b1, entry_index, rdata, STAT_INVALID};
			end else if (dec_v == lim_ext) begin
				// back to the small count: push the entry on the free list
				upd.mem_we    = 1'b1;
				upd.mem_wdata = {{(CNT_W-IDX_W){1'b0}}, free_head};
				upd.head_we   = 1'b1;
				upd.head_next = entry_index;
				upd.res       = '{1'b0, limit, '0, STAT_OK};
			end else begin
				upd.mem_we    = 1'b1;
				upd.mem_wdata = dec_v;
				upd.res       = '{1'b1, entry_index, dec_v, STAT_OK};
			end
		end
	end

endmodule

// ===== src/big_reference_counter_table_top.sv =====
// top level of the big reference counter table
//
// usage
// - command word in: kind, is_big, entry_index; taken at a rising edge with
//   start high and busy low
// - result word out: new_is_big, new_index, counter_value, status; valid for
//   exactly one cycle while done is high, no back-pressure from the receiver
// - config: cfg_we writes cfg_wdata into small_count_limit, no read-back;
//   write only while the block is idle
// - sequence: the accepting edge registers the counter memory read and enters
//   execute; done and the result are registered at the edge that ends execute
// - one word at a time: busy stays high in execute, as the counter memory is
//   read in the accept cycle and written back in the next one
// - a new word can be accepted in the same cycle the previous result shows
// - reset: busy stays high for CAPACITY cycles while a clearing pass writes
//   entry i with i+1 (the initial free chain); config writes are still taken
// - free_head resets to 0, small_count_limit resets to 32767
`include "big_reference_counter_table_top_defines.svh"

module big_reference_counter_table_top
	import bigrc_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	// command channel
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  logic             is_big,
	input  logic [IDX_W-1:0] entry_index,
	// config register
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata,
	// result channel
	output logic             done,
	output logic             new_is_big,
	output logic [IDX_W-1:0] new_index,
	output logic [CNT_W-1:0] counter_value,
	output logic [1:0]       status
);

	// memory address width, at least one bit
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IDX_W:0] CAP_EXT = (IDX_W+1)'(CAPACITY);
	localparam logic [AW-1:0]  CLR_LAST = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [IDX_W-1:0] free_head_q;
	logic [LIM_W-1:0] limit_q;

	// captured command word, one stage
	logic             kind_s1;
	logic             is_big_s1;
	logic [IDX_W-1:0] index_s1;

	// registered result
	logic    done_q;
	result_t res_q;

	logic             accept;
	logic [IDX_W-1:0] rd_sel;
	logic             rd_en;
	logic [CNT_W-1:0] rdata;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [CNT_W-1:0] mem_wdata;
	update_t          upd;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	// a take on a small object reads the free head, everything else the entry
	assign rd_sel = (kind == KIND_TAKE && !is_big) ? free_head_q : entry_index;
	assign rd_en  = accept && ({1'b0, rd_sel} < CAP_EXT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// write-back lands here, so the next read sees it
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			is_big_s1 <= is_big;
			index_s1  <= entry_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
		end else if (state_q == ST_EXEC && upd.head_we) begin
			free_head_q <= upd.head_next;
		end
	end

	bigrc_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_sel[AW-1:0]),
		.rdata (rdata)
	);

	bigrc_calc #(
		.CAPACITY (CAPACITY)
	) u_calc (
		.kind        (kind_s1),
		.is_big      (is_big_s1),
		.entry_index (index_s1),
		.limit       (limit_q),
		.free_head   (free_head_q),
		.rdata       (rdata),
		.upd         (upd)
	);

	// clearing pass owns the write port right after reset
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = {{(CNT_W-AW){1'b0}}, clr_q} + CNT_W'(1);
		end else begin
			mem_we    = (state_q == ST_EXEC) && upd.mem_we;
			mem_waddr = upd.mem_idx[AW-1:0];
			mem_wdata = upd.mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			res_q <= upd.res;
		end
	end

	assign done          = done_q;
	assign new_is_big    = res_q.new_is_big;
	assign new_index     = res_q.new_index;
	assign counter_value = res_q.counter_value;
	assign status        = res_q.status;

	// a result only follows an execute cycle
	`BIGRC_ASSERT(a_done_after_exec, clk, arst_n, done |-> $past(state_q == ST_EXEC), "done without execute")
	// the memory is never written while idle
	`BIGRC_ASSERT(a_no_write_idle, clk, arst_n, (state_q == ST_IDLE) |-> !mem_we, "write while idle")
	// a full table never hands out a big entry
	`BIGRC_ASSERT(a_full_small, clk, arst_n, (done && status == STAT_FULL) |-> !new_is_big, "full but big")
	// an accepted word is always followed by execute
	`BIGRC_ASSERT(a_accept_exec, clk, arst_n, accept |=> (state_q == ST_EXEC), "accept lost")
	// no result strobe while the clearing pass runs
	`BIGRC_ASSERT_ALWAYS(a_no_done_clear, clk, (state_q == ST_CLEAR) |-> !done, "done in clear")

endmodule
